// ===== sv/pvu_pkg.sv =====
// PageRank vertex update unit: shared types and constants.
// Holds controller states, command/status structs, operand selects and
// register codes. No dependencies.
`timescale 1ns / 1ps

package pvu_pkg;

	// Field widths and fixed-point formats
	localparam int VW = 32;           // value width, Q16.16
	localparam int WW = 17;           // weight width, Q0.16 plus the bit for one
	localparam int WF = WW - 1;       // weight fraction bits
	localparam int FRAC_V = 16;       // value fraction bits
	localparam int DEG_W = 16;        // target in-degree width
	localparam int CFG_IW = 2;        // configuration index width
	localparam int DIV_STEPS = 33;    // quotient bits of the jump term
	localparam int DIV_CW = 6;        // divider step counter width

	localparam logic [WW-1:0] ONE_W = WW'(1) << WF;
	localparam logic [VW-1:0] VMAX = '1;
	// Out-weight limit of one plus one part in 1e5, truncated
	localparam logic [VW-1:0] OWS_LIMIT = VW'((1 << WF) + (1 << WF) / 100000);

	// Reset values of the configuration registers
	localparam logic [WW-1:0] JUMP_RESET = WW'(6554);
	localparam logic [VW-1:0] VCOUNT_RESET = VW'(1);
	localparam logic [VW-1:0] PREC_RESET = VW'(1);

	typedef enum logic [CFG_IW-1:0] {
		CFG_JUMP,
		CFG_VCOUNT,
		CFG_MODE,
		CFG_PREC
	} cfg_index_t;

	typedef enum logic [1:0] {
		MODE_RANDOM,
		MODE_ALWAYS,
		MODE_DEGREE,
		MODE_THRESH
	} sched_mode_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_IN_SELF,
		ST_IN_EDGE,
		ST_IN_ACC,
		ST_T_LO,
		ST_T_HI,
		ST_T_ADD,
		ST_DIV_WAIT,
		ST_RES,
		ST_CMP0_ISSUE,
		ST_CMP0_EVAL,
		ST_AS_ISSUE,
		ST_AD_ISSUE,
		ST_M_ISSUE,
		ST_RHS_ISSUE,
		ST_CMP2_EVAL,
		ST_PRI_TAKE,
		ST_RESULT
	} pvu_state_t;

	// Operand pairs of the shared multiplier
	typedef enum logic [3:0] {
		MUL_SELF,    // self weight * old value
		MUL_EDGE,    // edge weight * source value
		MUL_T_LO,    // (one - jump) * edge sum low word
		MUL_T_HI,    // (one - jump) * edge sum high word
		MUL_RND_P,   // random draw * precision
		MUL_R_EW,    // residual * edge weight
		MUL_AS,      // (one - jump) * target self weight
		MUL_AD,      // (one - jump) * target in-degree
		MUL_M,       // previous product * residual
		MUL_RHS      // (full - as) * precision
	} mul_sel_t;

	typedef enum logic [1:0] {
		ES_HOLD,
		ES_LOAD,
		ES_ACC
	} es_op_t;

	typedef enum logic [1:0] {
		T_HOLD,
		T_LOAD,
		T_ADD
	} t_op_t;

	typedef enum logic [1:0] {
		SCH_HOLD,
		SCH_MODE0,
		SCH_MODE2
	} sch_op_t;

	typedef struct packed {
		logic        cap_item;
		mul_sel_t    mul_sel;
		es_op_t      es_op;
		logic        ld_first;
		t_op_t       t_op;
		logic        div_start;
		logic        ld_nv;
		logic        ld_res;
		logic        upd_ows;
		logic        cap_as;
		logic        cap_m;
		sch_op_t     sch_op;
		logic        ld_pri;
		logic        load_out;
	} pvu_cmd_t;

	typedef struct packed {
		logic        is_out;
		logic        first;
		logic        last;
		sched_mode_t mode;
		logic        div_done;
	} pvu_status_t;

endpackage

// ===== sv/pvu_div.sv =====
// Restoring divider for the jump term, one quotient bit per cycle.
// Depends on pvu_pkg.
`timescale 1ns / 1ps

module pvu_div
	import pvu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_STEPS-1:0] dividend,
	input  logic [VW-1:0]        divisor,
	output logic [DIV_STEPS-1:0] quotient,
	output logic                 done
);

	logic [DIV_CW-1:0]    cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [VW:0]          rem_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [VW:0]          rem_sh;
	logic                 ge;

	// Shift one dividend bit into the remainder and try the subtract
	always_comb begin
		rem_sh = {rem_q[VW-1:0], quo_q[DIV_STEPS-1]};
		ge = rem_sh >= {1'b0, divisor};
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= DIV_CW'(DIV_STEPS);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, divisor} : rem_sh;
			quo_q <= {quo_q[DIV_STEPS-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done = done_q;

endmodule

// ===== sv/pvu_ctrl.sv =====
// Controller of the PageRank vertex update unit: sequences the datapath
// one item at a time and owns the handshakes. Depends on pvu_pkg.
`timescale 1ns / 1ps

module pvu_ctrl
	import pvu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  pvu_status_t status,
	output pvu_cmd_t    ctl
);

	pvu_state_t state_q, state_d;
	logic       out_valid_q;

	// State and result valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		ctl = '0;
		ctl.mul_sel = MUL_EDGE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.cap_item = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (!status.is_out) begin
					ctl.div_start = status.last;
					state_d = status.first ? ST_IN_SELF : ST_IN_EDGE;
				end else begin
					ctl.upd_ows = 1'b1;
					unique case (status.mode)
						MODE_RANDOM: state_d = ST_CMP0_ISSUE;
						MODE_DEGREE: state_d = ST_AS_ISSUE;
						MODE_ALWAYS, MODE_THRESH: state_d = ST_RESULT;
						default: state_d = ST_RESULT;
					endcase
				end
			end
			ST_IN_SELF: begin
				ctl.mul_sel = MUL_SELF;
				state_d = ST_IN_EDGE;
			end
			ST_IN_EDGE: begin
				ctl.mul_sel = MUL_EDGE;
				if (status.first) begin
					ctl.es_op = ES_LOAD;
					ctl.ld_first = 1'b1;
				end
				state_d = ST_IN_ACC;
			end
			ST_IN_ACC: begin
				ctl.es_op = ES_ACC;
				state_d = status.last ? ST_T_LO : ST_RESULT;
			end
			ST_T_LO: begin
				ctl.mul_sel = MUL_T_LO;
				state_d = ST_T_HI;
			end
			ST_T_HI: begin
				ctl.mul_sel = MUL_T_HI;
				ctl.t_op = T_LOAD;
				state_d = ST_T_ADD;
			end
			ST_T_ADD: begin
				ctl.t_op = T_ADD;
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (status.div_done) begin
					ctl.ld_nv = 1'b1;
					state_d = ST_RES;
				end
			end
			ST_RES: begin
				ctl.ld_res = 1'b1;
				state_d = ST_RESULT;
			end
			ST_CMP0_ISSUE: begin
				ctl.mul_sel = MUL_RND_P;
				state_d = ST_CMP0_EVAL;
			end
			ST_CMP0_EVAL: begin
				ctl.sch_op = SCH_MODE0;
				ctl.mul_sel = MUL_R_EW;
				state_d = ST_PRI_TAKE;
			end
			ST_AS_ISSUE: begin
				ctl.mul_sel = MUL_AS;
				state_d = ST_AD_ISSUE;
			end
			ST_AD_ISSUE: begin
				ctl.cap_as = 1'b1;
				ctl.mul_sel = MUL_AD;
				state_d = ST_M_ISSUE;
			end
			ST_M_ISSUE: begin
				ctl.mul_sel = MUL_M;
				state_d = ST_RHS_ISSUE;
			end
			ST_RHS_ISSUE: begin
				ctl.cap_m = 1'b1;
				ctl.mul_sel = MUL_RHS;
				state_d = ST_CMP2_EVAL;
			end
			ST_CMP2_EVAL: begin
				ctl.sch_op = SCH_MODE2;
				ctl.mul_sel = MUL_R_EW;
				state_d = ST_PRI_TAKE;
			end
			ST_PRI_TAKE: begin
				ctl.ld_pri = 1'b1;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					ctl.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/pvu_dpath.sv =====
// Datapath of the PageRank vertex update unit: configuration registers,
// vertex state, shared multiplier, jump divider and result register.
// Depends on pvu_pkg and pvu_div.
`timescale 1ns / 1ps

module pvu_dpath
	import pvu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  pvu_cmd_t          ctl,
	output pvu_status_t       status,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [VW-1:0]     cfg_data,
	input  logic              cmd,
	input  logic              first,
	input  logic              last,
	input  logic [VW-1:0]     vertex_value,
	input  logic [WW-1:0]     self_weight,
	input  logic [WW-1:0]     edge_weight,
	input  logic [VW-1:0]     source_value,
	input  logic [WW-1:0]     random_draw,
	input  logic [DEG_W-1:0]  target_in_degree,
	input  logic [WW-1:0]     target_self_weight,
	output logic [VW-1:0]     new_value,
	output logic              schedule_target,
	output logic [VW-1:0]     residual,
	output logic [VW-1:0]     priority_res,
	output logic              weight_error
);

	// Configuration
	logic [WW-1:0] jump_q;
	logic [VW-1:0] vcount_q;
	sched_mode_t   mode_q;
	logic [VW-1:0] prec_q;

	// Captured item
	logic             item_cmd_q, item_first_q, item_last_q;
	logic [VW-1:0]    item_vv_q, item_sv_q;
	logic [WW-1:0]    item_sw_q, item_ew_q, item_rnd_q, item_tsw_q;
	logic [DEG_W-1:0] item_deg_q;

	// Vertex state
	logic [63:0]   es_q;
	logic [VW-1:0] old_q, cur_value_q, cur_res_q, ows_q;

	// Working registers
	logic [64:0]   prod_s1;
	logic [80:0]   t_q;
	logic [VW-1:0] nv_q, pri_q;
	logic [32:0]   as_q;
	logic          as_big_q;
	logic [63:0]   m_q;
	logic          sched_q;

	logic [WW-1:0]        jump_c, a_w;
	logic [VW-1:0]        divisor;
	logic [DIV_STEPS-1:0] jt;
	logic                 div_done;
	logic [32:0]          mul_a;
	logic [VW-1:0]        mul_b;
	logic [64:0]          es_sum, nv_sum;
	logic [VW:0]          ows_sum;
	logic                 sched_f, werr_f;
	logic [VW-1:0]        pri_f;

	// Clamp the jump to one and the vertex count to at least one
	always_comb begin
		jump_c = (jump_q > ONE_W) ? ONE_W : jump_q;
		a_w = ONE_W - jump_c;
		divisor = (vcount_q == '0) ? VW'(1) : vcount_q;
	end

	pvu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend ({jump_c, FRAC_V'(0)}),
		.divisor  (divisor),
		.quotient (jt),
		.done     (div_done)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_q <= JUMP_RESET;
			vcount_q <= VCOUNT_RESET;
			mode_q <= MODE_RANDOM;
			prec_q <= PREC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_JUMP:   jump_q <= cfg_data[WW-1:0];
				CFG_VCOUNT: vcount_q <= cfg_data;
				CFG_MODE:   mode_q <= sched_mode_t'(cfg_data[1:0]);
				CFG_PREC:   prec_q <= cfg_data;
				default:    prec_q <= prec_q;
			endcase
		end
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (ctl.cap_item) begin
			item_cmd_q <= cmd;
			item_first_q <= first;
			item_last_q <= last;
			item_vv_q <= vertex_value;
			item_sw_q <= self_weight;
			item_ew_q <= edge_weight;
			item_sv_q <= source_value;
			item_rnd_q <= random_draw;
			item_deg_q <= target_in_degree;
			item_tsw_q <= target_self_weight;
		end
	end

	// Select multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ctl.mul_sel)
			MUL_SELF:  begin mul_a = 33'(item_sw_q);  mul_b = item_vv_q; end
			MUL_EDGE:  begin mul_a = 33'(item_ew_q);  mul_b = item_sv_q; end
			MUL_T_LO:  begin mul_a = 33'(a_w);        mul_b = es_q[31:0]; end
			MUL_T_HI:  begin mul_a = 33'(a_w);        mul_b = es_q[63:32]; end
			MUL_RND_P: begin mul_a = 33'(item_rnd_q); mul_b = prec_q; end
			MUL_R_EW:  begin mul_a = 33'(item_ew_q);  mul_b = cur_res_q; end
			MUL_AS:    begin mul_a = 33'(a_w);        mul_b = VW'(item_tsw_q); end
			MUL_AD:    begin mul_a = 33'(a_w);        mul_b = VW'(item_deg_q); end
			MUL_M:     begin mul_a = prod_s1[32:0];   mul_b = cur_res_q; end
			MUL_RHS:   begin mul_a = 33'h1_0000_0000 - as_q; mul_b = prec_q; end
			default:   begin mul_a = '0;              mul_b = '0; end
		endcase
	end

	// Registered product
	always_ff @(posedge clk) begin
		prod_s1 <= 65'(mul_a) * 65'(mul_b);
	end

	// Saturating sums and the new value
	always_comb begin
		es_sum = {1'b0, es_q} + prod_s1;
		ows_sum = {1'b0, ows_q} + (VW + 1)'(item_ew_q);
		nv_sum = {1'b0, t_q[79:16]} + 65'(jt);
	end

	// Vertex state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			es_q <= '0;
			old_q <= '0;
			cur_value_q <= '0;
			cur_res_q <= '0;
			ows_q <= '0;
		end else begin
			unique case (ctl.es_op)
				ES_LOAD: es_q <= prod_s1[63:0];
				ES_ACC:  es_q <= es_sum[64] ? '1 : es_sum[63:0];
				default: es_q <= es_q;
			endcase
			if (ctl.ld_first)
				old_q <= item_vv_q;
			if (ctl.ld_res) begin
				cur_value_q <= nv_q;
				cur_res_q <= (nv_q > old_q) ? nv_q - old_q : old_q - nv_q;
			end
			// clear on a first or last in-edge and after a last out-edge
			if (ctl.ld_first || ctl.ld_res || (ctl.load_out && item_cmd_q && item_last_q))
				ows_q <= '0;
			else if (ctl.upd_ows)
				ows_q <= ows_sum[VW] ? VMAX : ows_sum[VW-1:0];
		end
	end

	// Working registers of the long sequences
	always_ff @(posedge clk) begin
		unique case (ctl.t_op)
			T_LOAD:  t_q <= 81'(prod_s1);
			T_ADD:   t_q <= t_q + {prod_s1[48:0], 32'b0};
			default: t_q <= t_q;
		endcase
		if (ctl.ld_nv)
			nv_q <= (nv_sum[64:48] != '0) ? VMAX : nv_sum[47:16];
		if (ctl.cap_as) begin
			as_q <= prod_s1[32:0];
			as_big_q <= prod_s1[64:32] != '0;
		end
		if (ctl.cap_m)
			m_q <= prod_s1[63:0];
		unique case (ctl.sch_op)
			SCH_MODE0: sched_q <= {17'b0, cur_res_q, 16'b0} >= prod_s1;
			SCH_MODE2: sched_q <= as_big_q || ({1'b0, m_q, 16'b0} >= {16'b0, prod_s1});
			default:   sched_q <= sched_q;
		endcase
		if (ctl.ld_pri)
			pri_q <= (prod_s1[64:48] != '0) ? VMAX : prod_s1[47:16];
	end

	// Out-edge decision
	always_comb begin
		unique case (mode_q)
			MODE_ALWAYS: sched_f = 1'b1;
			MODE_THRESH: sched_f = cur_res_q > prec_q;
			default:     sched_f = sched_q;
		endcase
		if (!sched_f)
			pri_f = '0;
		else if (mode_q == MODE_ALWAYS || mode_q == MODE_THRESH)
			pri_f = cur_res_q;
		else
			pri_f = pri_q;
		werr_f = item_last_q && (ows_q > OWS_LIMIT);
	end

	// Result register
	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			if (!item_cmd_q) begin
				new_value <= item_last_q ? cur_value_q : '0;
				residual <= item_last_q ? cur_res_q : '0;
				schedule_target <= 1'b0;
				priority_res <= '0;
				weight_error <= 1'b0;
			end else begin
				new_value <= '0;
				residual <= '0;
				schedule_target <= sched_f;
				priority_res <= pri_f;
				weight_error <= werr_f;
			end
		end
	end

	assign status.is_out = item_cmd_q;
	assign status.first = item_first_q;
	assign status.last = item_last_q;
	assign status.mode = mode_q;
	assign status.div_done = div_done;

endmodule

// ===== sv/pagerank_vertex_update_unit.sv =====
// Top level of the PageRank vertex update unit with residual scheduling.
// Depends on pvu_pkg, pvu_ctrl and pvu_dpath.
//
// channel  handshake                  payload
// in       in_valid / in_ready        cmd .. target_self_weight
// out      out_valid / out_ready      new_value .. weight_error
// cfg      cfg_we                     cfg_index, cfg_data
//
// One item at a time: an in-edge passes the self (with first), edge and
// accumulate states, and a last in-edge then waits on the 33-step jump
// divider; an out-edge goes on to the result in modes 1 and 3 and passes
// through the one shared multiplier in modes 0 and 2. Reset clears the
// control, configuration and vertex state at once; no clearing pass. A
// stalled result waits in the output register while the next item is taken.
`timescale 1ns / 1ps

module pagerank_vertex_update_unit
	import pvu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [VW-1:0]     cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic              first,
	input  logic              last,
	input  logic [VW-1:0]     vertex_value,
	input  logic [WW-1:0]     self_weight,
	input  logic [WW-1:0]     edge_weight,
	input  logic [VW-1:0]     source_value,
	input  logic [WW-1:0]     random_draw,
	input  logic [DEG_W-1:0]  target_in_degree,
	input  logic [WW-1:0]     target_self_weight,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [VW-1:0]     new_value,
	output logic [VW-1:0]     residual,
	output logic              schedule_target,
	output logic [VW-1:0]     priority_res,
	output logic              weight_error
);

	pvu_cmd_t    ctl;
	pvu_status_t status;

	pvu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.ctl       (ctl)
	);

	pvu_dpath u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctl                (ctl),
		.status             (status),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.cmd                (cmd),
		.first              (first),
		.last               (last),
		.vertex_value       (vertex_value),
		.self_weight        (self_weight),
		.edge_weight        (edge_weight),
		.source_value       (source_value),
		.random_draw        (random_draw),
		.target_in_degree   (target_in_degree),
		.target_self_weight (target_self_weight),
		.new_value          (new_value),
		.schedule_target    (schedule_target),
		.residual           (residual),
		.priority_res       (priority_res),
		.weight_error       (weight_error)
	);

endmodule
